/* rtl/sde_pkg.sv */
`timescale 1ns / 1ps

package sde_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int MEAN_W      = 24;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int SUM_W       = 64;
  localparam int CNT_W       = 16;
  localparam int VAR_W       = 48;
  localparam int DEV_W       = 24;
  localparam int REM_W       = DEV_W + 2;
  localparam int SU_W        = REM_W + 2;
  localparam int ITR_W       = 6;
  localparam int DIV_STEPS   = SUM_W;
  localparam int SQRT_STEPS  = DEV_W;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = VAR_W + DEV_W;

  localparam logic [CNT_W-1:0] MAX_SAMPLES = 16'hFFFF;
  localparam logic [ITR_W-1:0] DIV_LAST    = ITR_W'(DIV_STEPS - 1);
  localparam logic [ITR_W-1:0] SQRT_LAST   = ITR_W'(SQRT_STEPS - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ACC  = 6'b000100,
    S_DIV  = 6'b001000,
    S_SQRT = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

endpackage

/* rtl/standard_deviation_engine.sv */
`timescale 1ns / 1ps
// A sample word is taken through accept, square and accumulate in turn.
// A word with tlast then adds restoring division and square root, both on one shared
// 28-bit subtract unit; the result is then loaded into the output register, raising
// out_tvalid, once that register is empty or being read, and the input is ready again.
// The input is not ready while a word is in work; the result sits in an output register.
// rst_n is synchronous, active low: clears the mean, the sum, the count, the overflow flag
// and the output valid.

module standard_deviation_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sde_pkg::IN_DATA_W-1:0]     in_tdata,   // [23:0] sample_value
  input  logic                              in_tlast,   // last_sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sde_pkg::OUT_DATA_W-1:0]    out_tdata,  // [47:0] variance, [71:48] deviation
  output logic                              out_tuser,  // count_overflow
  input  logic                              cfg_wr_en,
  input  logic [sde_pkg::MEAN_W-1:0]        cfg_wr_data // mean_value
);

  sde_pkg::state_t state_r, state_nxt;

  logic [sde_pkg::MEAN_W-1:0]   mean_r;
  logic [sde_pkg::SAMPLE_W-1:0] sample_r;
  logic                         last_r;
  logic [sde_pkg::PROD_W-1:0]   prod_r;
  logic [sde_pkg::SUM_W-1:0]    sum_r;
  logic [sde_pkg::CNT_W-1:0]    cnt_r;
  logic                         ovf_r;
  logic [sde_pkg::REM_W-1:0]    rem_r;
  logic [sde_pkg::DEV_W-1:0]    root_r;
  logic [sde_pkg::VAR_W-1:0]    var_r;
  logic [sde_pkg::ITR_W-1:0]    itr_r;
  logic [sde_pkg::VAR_W-1:0]    out_var_r;
  logic [sde_pkg::DEV_W-1:0]    out_dev_r;
  logic                         out_ovf_r;
  logic                         out_valid_r;

  logic                         in_fire;
  logic                         emit_fire;
  logic [sde_pkg::SAMPLE_W-1:0] mag;
  logic [sde_pkg::SUM_W:0]      acc_sum;
  logic [sde_pkg::SUM_W-1:0]    quot;
  logic [sde_pkg::VAR_W-1:0]    var_sat;

  // shared subtract / compare unit
  logic [sde_pkg::SU_W-1:0]     su_a, su_b;
  logic [sde_pkg::SU_W:0]       su_diff;
  logic                         su_ge;
  logic [sde_pkg::REM_W-1:0]    rem_upd;

  assign in_tready  = (state_r == sde_pkg::S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign emit_fire  = (state_r == sde_pkg::S_EMIT) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dev_r, out_var_r};
  assign out_tuser  = out_ovf_r;

  assign mag     = (sample_r >= mean_r) ? (sample_r - mean_r) : (mean_r - sample_r);
  assign acc_sum = {1'b0, sum_r} + {{(sde_pkg::SUM_W - sde_pkg::PROD_W + 1){1'b0}}, prod_r};

  always_comb begin
    su_a = '0;
    su_b = '0;
    case (state_r)
      sde_pkg::S_DIV: begin
        su_a = {{(sde_pkg::SU_W - sde_pkg::CNT_W - 1){1'b0}},
                rem_r[sde_pkg::CNT_W-1:0], sum_r[sde_pkg::SUM_W-1]};
        su_b = {{(sde_pkg::SU_W - sde_pkg::CNT_W){1'b0}}, cnt_r};
      end
      sde_pkg::S_SQRT: begin
        su_a = {rem_r, sum_r[sde_pkg::VAR_W-1 -: 2]};
        su_b = {2'b00, root_r, 2'b01};
      end
      default: begin
        su_a = '0;
        su_b = '0;
      end
    endcase
  end

  assign su_diff = {1'b0, su_a} - {1'b0, su_b};
  assign su_ge   = !su_diff[sde_pkg::SU_W];
  assign rem_upd = su_ge ? su_diff[sde_pkg::REM_W-1:0] : su_a[sde_pkg::REM_W-1:0];

  assign quot    = {sum_r[sde_pkg::SUM_W-2:0], su_ge};
  assign var_sat = (|quot[sde_pkg::SUM_W-1:sde_pkg::VAR_W]) ? {sde_pkg::VAR_W{1'b1}}
                                                            : quot[sde_pkg::VAR_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sde_pkg::S_IDLE: if (in_fire) state_nxt = sde_pkg::S_MUL;
      sde_pkg::S_MUL:  state_nxt = sde_pkg::S_ACC;
      sde_pkg::S_ACC:  state_nxt = last_r ? sde_pkg::S_DIV : sde_pkg::S_IDLE;
      sde_pkg::S_DIV:  if (itr_r == sde_pkg::DIV_LAST) state_nxt = sde_pkg::S_SQRT;
      sde_pkg::S_SQRT: if (itr_r == sde_pkg::SQRT_LAST) state_nxt = sde_pkg::S_EMIT;
      sde_pkg::S_EMIT: if (emit_fire) state_nxt = sde_pkg::S_IDLE;
      default:         state_nxt = sde_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sde_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      mean_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      itr_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        mean_r <= cfg_wr_data;
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        sde_pkg::S_ACC: begin
          if (cnt_r == sde_pkg::MAX_SAMPLES) begin
            ovf_r <= 1'b1;
          end else begin
            sum_r <= acc_sum[sde_pkg::SUM_W] ? {sde_pkg::SUM_W{1'b1}}
                                             : acc_sum[sde_pkg::SUM_W-1:0];
            cnt_r <= cnt_r + 1'b1;
          end
          itr_r <= '0;
        end
        sde_pkg::S_DIV: begin
          if (itr_r == sde_pkg::DIV_LAST) begin
            sum_r <= {{(sde_pkg::SUM_W - sde_pkg::VAR_W){1'b0}}, var_sat};
            itr_r <= '0;
          end else begin
            sum_r <= quot;
            itr_r <= itr_r + 1'b1;
          end
        end
        sde_pkg::S_SQRT: begin
          sum_r <= {sum_r[sde_pkg::SUM_W-3:0], 2'b00};
          itr_r <= itr_r + 1'b1;
        end
        sde_pkg::S_EMIT: begin
          if (emit_fire) begin
            sum_r <= '0;
            cnt_r <= '0;
            ovf_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_tdata[sde_pkg::SAMPLE_W-1:0];
      last_r   <= in_tlast;
    end
    if (state_r == sde_pkg::S_MUL) begin
      prod_r <= {{sde_pkg::SAMPLE_W{1'b0}}, mag} * {{sde_pkg::SAMPLE_W{1'b0}}, mag};
    end
    case (state_r)
      sde_pkg::S_ACC: begin
        rem_r  <= '0;
        root_r <= '0;
      end
      sde_pkg::S_DIV: begin
        if (itr_r == sde_pkg::DIV_LAST) begin
          rem_r <= '0;
          var_r <= var_sat;
        end else begin
          rem_r <= rem_upd;
        end
      end
      sde_pkg::S_SQRT: begin
        rem_r  <= rem_upd;
        root_r <= {root_r[sde_pkg::DEV_W-2:0], su_ge};
      end
      default: begin
      end
    endcase
    if (emit_fire) begin
      out_var_r <= var_r;
      out_dev_r <= root_r;
      out_ovf_r <= ovf_r;
    end
  end

endmodule

/* rtl/sde_checker.sv */
`timescale 1ns / 1ps

module sde_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [sde_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [sde_pkg::VAR_W:0] dev_sq;
  logic [sde_pkg::VAR_W:0] dev1_sq;
  logic [sde_pkg::VAR_W:0] var_x;

  assign var_x   = {1'b0, out_tdata[sde_pkg::VAR_W-1:0]};
  assign dev_sq  = {{(sde_pkg::VAR_W + 1 - sde_pkg::DEV_W){1'b0}},
                    out_tdata[sde_pkg::OUT_DATA_W-1:sde_pkg::VAR_W]} *
                   {{(sde_pkg::VAR_W + 1 - sde_pkg::DEV_W){1'b0}},
                    out_tdata[sde_pkg::OUT_DATA_W-1:sde_pkg::VAR_W]};
  assign dev1_sq = dev_sq + {{(sde_pkg::VAR_W - sde_pkg::DEV_W){1'b0}},
                             out_tdata[sde_pkg::OUT_DATA_W-1:sde_pkg::VAR_W], 1'b0} +
                   (sde_pkg::VAR_W + 1)'(1);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a word");

  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (dev_sq <= var_x) && (dev1_sq > var_x))
    else $error("deviation is not the floor root of the variance");

endmodule

bind standard_deviation_engine sde_checker u_sde_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam logic [sde_pkg::SAMPLE_W-1:0] SAMPLE_MAX = '1;
  localparam logic [sde_pkg::SUM_W-1:0]    SUM_MAX    = '1;
  localparam logic [sde_pkg::VAR_W-1:0]    VAR_MAX    = '1;
  localparam int                           RANDOM_WORDS = 1500;

  typedef struct packed {
    logic [sde_pkg::VAR_W-1:0] variance;
    logic [sde_pkg::DEV_W-1:0] deviation;
    logic                      overflow;
  } stat_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [sde_pkg::IN_DATA_W-1:0]  in_tdata = '0;   // [23:0] sample_value
  logic                           in_tlast = 1'b0; // last_sample
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [sde_pkg::OUT_DATA_W-1:0] out_tdata;       // [47:0] variance, [71:48] deviation
  logic                           out_tuser;       // count_overflow
  logic                           cfg_wr_en = 1'b0;
  logic [sde_pkg::MEAN_W-1:0]     cfg_wr_data = '0;

  standard_deviation_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [sde_pkg::SAMPLE_W-1:0] mean_reg = '0;
  logic [sde_pkg::SUM_W-1:0]    acc_sum = '0;
  logic [sde_pkg::CNT_W-1:0]    acc_count = '0;
  logic                         acc_over = 1'b0;
  stat_result_t                 pending_stats[$];
  stat_result_t                 front_stat;

  int  errors = 0;
  int  words_sent = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;

  // receiver control
  int  hold_ticket = 0;
  int  hold_taken = 0;
  int  hold_left = 0;
  int  rx_mode = 0;
  int  rx_phase = 0;

  function automatic logic [sde_pkg::DEV_W-1:0] floor_root(
    input logic [sde_pkg::VAR_W-1:0] v);
    logic [sde_pkg::DEV_W-1:0] r;
    logic [sde_pkg::DEV_W-1:0] t;
    r = '0;
    for (int b = sde_pkg::DEV_W - 1; b >= 0; b--) begin
      t = r | (sde_pkg::DEV_W'(1) << b);
      if (sde_pkg::VAR_W'(t) * sde_pkg::VAR_W'(t) <= v) r = t;
    end
    return r;
  endfunction

  task automatic accumulate_sample(input logic [sde_pkg::SAMPLE_W-1:0] s, input logic last);
    logic [sde_pkg::SAMPLE_W-1:0] delta;
    logic [2*sde_pkg::SAMPLE_W-1:0] sq;
    logic [sde_pkg::SUM_W-1:0] quot;
    stat_result_t r;
    delta = (s >= mean_reg) ? s - mean_reg : mean_reg - s;
    sq = (2*sde_pkg::SAMPLE_W)'(delta) * (2*sde_pkg::SAMPLE_W)'(delta);
    if (acc_count == sde_pkg::MAX_SAMPLES) begin
      acc_over = 1'b1;
    end else begin
      acc_sum = (acc_sum > SUM_MAX - sde_pkg::SUM_W'(sq)) ? SUM_MAX
                                                          : acc_sum + sde_pkg::SUM_W'(sq);
      acc_count++;
    end
    if (last) begin
      quot = (acc_count != 0) ? acc_sum / sde_pkg::SUM_W'(acc_count) : '0;
      r.variance = (quot > sde_pkg::SUM_W'(VAR_MAX)) ? VAR_MAX : quot[sde_pkg::VAR_W-1:0];
      r.deviation = floor_root(r.variance);
      r.overflow = acc_over;
      pending_stats.push_back(r);
      acc_sum = '0;
      acc_count = '0;
      acc_over = 1'b0;
    end
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_sample(input logic [sde_pkg::SAMPLE_W-1:0] s, input logic last);
    in_tdata <= s;
    in_tlast <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    accumulate_sample(s, last);
    words_sent++;
    pace();
  endtask

  task automatic stop_stream();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_mean(input logic [sde_pkg::MEAN_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mean_reg = v;
    @(posedge clk);
  endtask

  function automatic logic [sde_pkg::SAMPLE_W-1:0] pick_sample();
    longint v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = SAMPLE_MAX;
      2, 3, 4, 5: v = longint'(mean_reg) + $urandom_range(0, 8192) - 4096;
      default: v = $urandom;
    endcase
    if (v < 0) v = 0;
    if (v > longint'(SAMPLE_MAX)) v = SAMPLE_MAX;
    return v[sde_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  task automatic test_extremes();
    gaps_on = 1'b0;
    write_mean('0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample('0, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample('0, 1'b1);
    stop_stream();
    write_mean(SAMPLE_MAX);
    send_sample('0, 1'b1);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample('0, 1'b0);
    send_sample('0, 1'b0);
    send_sample(24'h000001, 1'b1);
    stop_stream();
  endtask

  task automatic test_zero_variance();
    gaps_on = 1'b1;
    write_mean(24'h003039);
    repeat (4) send_sample(24'h003039, 1'b0);
    send_sample(24'h003039, 1'b1);
    send_sample(24'h003038, 1'b0);
    send_sample(24'h00303A, 1'b1);
    stop_stream();
  endtask

  task automatic test_mixed_set();
    write_mean(24'd1000);
    send_sample(24'd0, 1'b0);
    send_sample(24'd2000, 1'b0);
    send_sample(24'd500, 1'b0);
    send_sample(24'd1500, 1'b0);
    send_sample(24'd1003, 1'b1);
    send_sample(24'hAAAAAA, 1'b0);
    send_sample(24'h555555, 1'b1);
    stop_stream();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    write_mean(24'($urandom));
    hold_ticket++;
    repeat (40) send_set($urandom_range(1, 3));
    stop_stream();
  endtask

  task automatic test_random_sets();
    int phase;
    int target;
    phase = 0;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      stop_stream();
      case (phase % 6)
        0: write_mean('0);
        1: write_mean(SAMPLE_MAX);
        2: write_mean(24'($urandom_range(1, 255)));
        default: write_mean(24'($urandom));
      endcase
      gaps_on = (phase % 3) != 1;
      for (int k = 0; k < 60 && words_sent < target; k++) begin
        if ($urandom_range(0, 9) == 0) send_set($urandom_range(9, 60));
        else send_set($urandom_range(1, 8));
      end
      phase++;
    end
    stop_stream();
  endtask

  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_phase % 256 == 0) rx_mode <= $urandom_range(0, 4);
    if (hold_taken != hold_ticket) begin
      hold_taken <= hold_ticket;
      hold_left <= 400;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= $urandom_range(0, 9) != 0;
        3: out_tready <= (rx_phase % 8) != 0;
        default: out_tready <= (rx_phase % 4) == 3;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual data %h overflow %b",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        front_stat = pending_stats.pop_front();
        if (out_tdata[sde_pkg::VAR_W-1:0] !== front_stat.variance) begin
          $display("%0t: variance mismatch, expected %h, actual %h",
                   $time, front_stat.variance, out_tdata[sde_pkg::VAR_W-1:0]);
          errors++;
        end
        if (out_tdata[sde_pkg::VAR_W +: sde_pkg::DEV_W] !== front_stat.deviation) begin
          $display("%0t: deviation mismatch, expected %h, actual %h",
                   $time, front_stat.deviation, out_tdata[sde_pkg::VAR_W +: sde_pkg::DEV_W]);
          errors++;
        end
        if (out_tuser !== front_stat.overflow) begin
          $display("%0t: overflow mismatch, expected %b, actual %b",
                   $time, front_stat.overflow, out_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_zero_variance();
    test_mixed_set();
    test_backpressure();
    test_random_sets();
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sde_pkg.sv
rtl/standard_deviation_engine.sv
rtl/sde_checker.sv
test/tb_top.sv
